>>> rtl/piecewise_linear_interpolator_top_macros.svh
// Assertion macros used by the top level of the interpolation table RTL.
// Needs a clock named clk and an active-high reset named rst in scope.
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_TOP_MACROS_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PLI_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("interpolator check failed");

// Next-cycle implication, checked outside reset.
`define PLI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("interpolator check failed");

`endif

>>> rtl/pli_pkg.sv
// Shared types and constants of the piecewise linear interpolation table.
// No dependencies; used by the controller, the datapath and the top level.
package pli_pkg;

  localparam int MAX_NODES_DEF = 64;
  localparam int DATA_W        = 32;
  localparam int GAP_W         = 16;
  localparam int KIND_W        = 2;
  localparam int STATUS_W      = 3;
  localparam int COUNT_OUT_W   = 7;
  localparam int DIV_STEPS     = 64;
  localparam int DIV_CNT_W     = 6;
  localparam logic [GAP_W-1:0] GAP_RESET = 16'd7;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR = 2'd0,
    KIND_ADD   = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_NOP   = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 3'd0,
    ST_DUP   = 3'd1,
    ST_RANGE = 3'd2,
    ST_FULL  = 3'd3,
    ST_BAD   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    RES_ZERO   = 2'd0,
    RES_NODE   = 2'd1,
    RES_INTERP = 2'd2
  } res_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load;
    logic     add_proc;
    logic     q_proc;
    logic     ins_zero;
    logic     mul;
    logic     div_step;
    logic     emit;
    res_sel_t res_sel;
    status_t  status;
    logic     clr;
    logic     inc;
    logic     set_bad;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic dup;
    logic inserted;
    logic found;
    logic exact;
    logic at_first;
    logic bad;
    logic out_busy;
  } sts_t;

endpackage

>>> rtl/pli_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module pli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/pli_ctrl.sv
// Controller state machine of the interpolation table.
// Depends on pli_pkg; drives the datapath through cmd_t and reads sts_t.
module pli_ctrl #(
  parameter int MAX_NODES = pli_pkg::MAX_NODES_DEF,
  parameter int AW        = $clog2(MAX_NODES),
  parameter int CW        = $clog2(MAX_NODES + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [pli_pkg::KIND_W-1:0]  kind,
  input  logic [CW-1:0]               count,
  input  pli_pkg::sts_t               sts,
  output pli_pkg::cmd_t               cmd,
  output logic [AW-1:0]               rd_addr,
  output logic [AW-1:0]               proc_idx
);
  import pli_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_ADD_SCAN, S_ADD_DRAIN, S_ADD_END, S_Q_SCAN, S_Q_DRAIN,
    S_Q_DECIDE, S_MUL, S_DIV, S_EMIT
  } state_t;

  state_t               state;
  kind_t                op;
  logic [AW-1:0]        idx;
  logic [AW-1:0]        pidx;
  logic                 pend;
  logic [DIV_CNT_W-1:0] div_cnt;
  status_t              e_status;
  res_sel_t             e_res;
  logic                 e_clr;
  logic                 e_inc;
  logic                 e_bad;

  assign in_ready = (state == S_IDLE);
  assign rd_addr  = idx;
  assign proc_idx = pidx;

  // Commands decoded from state.
  always_comb begin
    cmd          = '0;
    cmd.load     = in_valid && (state == S_IDLE);
    cmd.add_proc = pend && (op == KIND_ADD);
    cmd.q_proc   = pend && (op == KIND_QUERY);
    cmd.ins_zero = (state == S_ADD_END) && !sts.inserted;
    cmd.mul      = (state == S_MUL);
    cmd.div_step = (state == S_DIV);
    cmd.emit     = (state == S_EMIT) && !sts.out_busy;
    cmd.res_sel  = e_res;
    cmd.status   = e_status;
    cmd.clr      = e_clr;
    cmd.inc      = e_inc;
    cmd.set_bad  = e_bad;
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      op       <= KIND_NOP;
      idx      <= '0;
      pidx     <= '0;
      pend     <= 1'b0;
      div_cnt  <= '0;
      e_status <= ST_OK;
      e_res    <= RES_ZERO;
      e_clr    <= 1'b0;
      e_inc    <= 1'b0;
      e_bad    <= 1'b0;
    end else begin
      pend <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op       <= kind_t'(kind);
            e_status <= ST_OK;
            e_res    <= RES_ZERO;
            e_clr    <= 1'b0;
            e_inc    <= 1'b0;
            e_bad    <= 1'b0;
            case (kind_t'(kind))
              KIND_CLEAR: begin
                e_clr <= 1'b1;
                state <= S_EMIT;
              end
              KIND_ADD: begin
                if (count >= CW'(MAX_NODES)) begin
                  e_status <= ST_FULL;
                  state    <= S_EMIT;
                end else if (count == '0) begin
                  state <= S_ADD_END;
                end else begin
                  idx   <= AW'(count - CW'(1));
                  state <= S_ADD_SCAN;
                end
              end
              KIND_QUERY: begin
                if (count == '0 || sts.bad) begin
                  e_status <= ST_BAD;
                  state    <= S_EMIT;
                end else begin
                  idx   <= '0;
                  state <= S_Q_SCAN;
                end
              end
              default: begin
                state <= S_EMIT;
              end
            endcase
          end
        end
        // Walk the table from the top down, one read per cycle.
        S_ADD_SCAN: begin
          pend <= 1'b1;
          pidx <= idx;
          if (idx == '0) begin
            state <= S_ADD_DRAIN;
          end else begin
            idx <= idx - AW'(1);
          end
        end
        S_ADD_DRAIN: begin
          state <= S_ADD_END;
        end
        S_ADD_END: begin
          e_status <= sts.dup ? ST_DUP : ST_OK;
          e_inc    <= 1'b1;
          e_bad    <= sts.dup;
          state    <= S_EMIT;
        end
        // Walk the table from the bottom up for the bracketing nodes.
        S_Q_SCAN: begin
          pend <= 1'b1;
          pidx <= idx;
          if (idx == AW'(count - CW'(1))) begin
            state <= S_Q_DRAIN;
          end else begin
            idx <= idx + AW'(1);
          end
        end
        S_Q_DRAIN: begin
          state <= S_Q_DECIDE;
        end
        S_Q_DECIDE: begin
          if (!sts.found || (!sts.exact && sts.at_first)) begin
            e_status <= ST_RANGE;
            state    <= S_EMIT;
          end else if (sts.exact) begin
            e_res <= RES_NODE;
            state <= S_EMIT;
          end else begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          div_cnt <= '0;
          state   <= S_DIV;
        end
        S_DIV: begin
          div_cnt <= div_cnt + DIV_CNT_W'(1);
          if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
            e_res <= RES_INTERP;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!sts.out_busy) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/pli_dp.sv
// Datapath of the interpolation table: node RAMs, compares, multiplier,
// serial divider and output word register. Depends on pli_pkg and pli_ram.
module pli_dp #(
  parameter int MAX_NODES = pli_pkg::MAX_NODES_DEF,
  parameter int AW        = $clog2(MAX_NODES),
  parameter int CW        = $clog2(MAX_NODES + 1)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic signed [pli_pkg::DATA_W-1:0] x_value,
  input  logic signed [pli_pkg::DATA_W-1:0] y_value,
  input  logic                              cfg_we,
  input  logic [pli_pkg::GAP_W-1:0]         cfg_data,
  input  pli_pkg::cmd_t                     cmd,
  input  logic [AW-1:0]                     rd_addr,
  input  logic [AW-1:0]                     proc_idx,
  output pli_pkg::sts_t                     sts,
  output logic [CW-1:0]                     count,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [pli_pkg::STATUS_W-1:0]      status,
  output logic signed [pli_pkg::DATA_W-1:0] y_result,
  output logic [pli_pkg::COUNT_OUT_W-1:0]   node_count
);
  import pli_pkg::*;

  logic [GAP_W-1:0]         gap;
  logic signed [DATA_W-1:0] x_in, y_in;
  logic signed [DATA_W-1:0] prev_x, prev_y, x0, x1, y0, y1;
  logic                     bad, dup, inserted, found, exact, at_first;
  logic [2*DATA_W-1:0]      dvd;
  logic [DATA_W-1:0]        rem;
  logic signed [DATA_W-1:0] rx, ry;
  logic                     we;
  logic [AW-1:0]            waddr;
  logic [DATA_W-1:0]        wx, wy;
  logic signed [DATA_W:0]   xdiff;
  logic [DATA_W:0]          xdist;
  logic                     dup_hit;
  logic signed [DATA_W:0]   dx_w, span_w, ydiff;
  logic [DATA_W-1:0]        dx, span, mag;
  logic [DATA_W:0]          trial;
  logic signed [DATA_W+1:0] sum;
  logic signed [DATA_W-1:0] interp;
  logic [CW-1:0]            count_next;

  pli_ram #(.WIDTH(DATA_W), .DEPTH(MAX_NODES)) u_ram_x (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wx), .raddr(rd_addr), .rdata(rx)
  );
  pli_ram #(.WIDTH(DATA_W), .DEPTH(MAX_NODES)) u_ram_y (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wy), .raddr(rd_addr), .rdata(ry)
  );

  // Duplicate test against the node just read.
  assign xdiff   = {rx[DATA_W-1], rx} - {x_in[DATA_W-1], x_in};
  assign xdist   = xdiff[DATA_W] ? (DATA_W+1)'(0) - xdiff : xdiff;
  assign dup_hit = (xdist == '0) || (xdist < {{(DATA_W+1-GAP_W){1'b0}}, gap});

  // Sorted insert: shift larger nodes up, drop the new node in the gap.
  always_comb begin
    we    = 1'b0;
    waddr = proc_idx + AW'(1);
    wx    = rx;
    wy    = ry;
    if (cmd.add_proc && !inserted) begin
      we = 1'b1;
      if (!(rx > x_in)) begin
        wx = x_in;
        wy = y_in;
      end
    end else if (cmd.ins_zero) begin
      we    = 1'b1;
      waddr = '0;
      wx    = x_in;
      wy    = y_in;
    end
  end

  // Interpolation operands and the divider step.
  assign dx_w   = {x_in[DATA_W-1], x_in} - {x0[DATA_W-1], x0};
  assign span_w = {x1[DATA_W-1], x1} - {x0[DATA_W-1], x0};
  assign ydiff  = {y1[DATA_W-1], y1} - {y0[DATA_W-1], y0};
  assign dx     = dx_w[DATA_W-1:0];
  assign span   = span_w[DATA_W-1:0];
  assign mag    = ydiff[DATA_W] ? DATA_W'(-ydiff) : ydiff[DATA_W-1:0];
  assign trial  = {rem, dvd[2*DATA_W-1]};

  // The quotient takes the sign of y1 - y0 and is added to y0.
  always_comb begin
    if (y1 >= y0) begin
      sum = {{2{y0[DATA_W-1]}}, y0} + {2'b00, dvd[DATA_W-1:0]};
    end else begin
      sum = {{2{y0[DATA_W-1]}}, y0} - {2'b00, dvd[DATA_W-1:0]};
    end
    if (sum[DATA_W+1:DATA_W-1] == 3'b000 || sum[DATA_W+1:DATA_W-1] == 3'b111) begin
      interp = sum[DATA_W-1:0];
    end else if (sum[DATA_W+1]) begin
      interp = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      interp = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  always_comb begin
    count_next = count;
    if (cmd.clr) begin
      count_next = '0;
    end else if (cmd.inc) begin
      count_next = count + CW'(1);
    end
  end

  assign sts.dup      = dup;
  assign sts.inserted = inserted;
  assign sts.found    = found;
  assign sts.exact    = exact;
  assign sts.at_first = at_first;
  assign sts.bad      = bad;
  assign sts.out_busy = out_valid && !out_ready;

  // Control state: register, count, bad mark, output handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      gap       <= GAP_RESET;
      count     <= '0;
      bad       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        gap <= cfg_data;
      end
      if (cmd.emit) begin
        count     <= count_next;
        bad       <= cmd.clr ? 1'b0 : (bad || cmd.set_bad);
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers of the current word.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_in     <= x_value;
      y_in     <= y_value;
      dup      <= 1'b0;
      inserted <= 1'b0;
      found    <= 1'b0;
      exact    <= 1'b0;
      at_first <= 1'b0;
    end
    if (cmd.add_proc) begin
      if (dup_hit) begin
        dup <= 1'b1;
      end
      if (!(rx > x_in)) begin
        inserted <= 1'b1;
      end
    end
    if (cmd.q_proc) begin
      prev_x <= rx;
      prev_y <= ry;
      if (!found && rx >= x_in) begin
        found    <= 1'b1;
        exact    <= (rx == x_in);
        at_first <= (proc_idx == '0);
        x1       <= rx;
        y1       <= ry;
        x0       <= prev_x;
        y0       <= prev_y;
      end
    end
    if (cmd.mul) begin
      dvd <= mag * dx;
      rem <= '0;
    end else if (cmd.div_step) begin
      if (trial >= {1'b0, span}) begin
        rem <= DATA_W'(trial - {1'b0, span});
        dvd <= {dvd[2*DATA_W-2:0], 1'b1};
      end else begin
        rem <= trial[DATA_W-1:0];
        dvd <= {dvd[2*DATA_W-2:0], 1'b0};
      end
    end
    if (cmd.emit) begin
      status     <= cmd.status;
      node_count <= COUNT_OUT_W'(count_next);
      case (cmd.res_sel)
        RES_NODE:   y_result <= y1;
        RES_INTERP: y_result <= interp;
        default:    y_result <= '0;
      endcase
    end
  end

endmodule

>>> rtl/piecewise_linear_interpolator_top.sv
// Piecewise linear interpolation table over signed Q16.16 nodes.
// Input channel: in_valid/in_ready with kind, x_value, y_value (one word per
// operation: clear, add node, query, no operation). Output channel:
// out_valid/out_ready with status, y_result, node_count, one word per input.
// cfg_we/cfg_data write min_node_gap; write it only while the block is idle.
// One word is worked at a time. An add walks the node RAM serially, shifting
// larger nodes up; an add on an empty table skips the walk. A query walks the
// RAM for the bracketing nodes, then multiplies and runs a 64-step restoring
// divider; errors and exact hits skip the multiply and the divider.
// Clear, no operation, a table-full add and a query on a bad or empty table
// go straight to the output word.
// Reset empties the table, lifts the bad mark and sets min_node_gap to 7.
// The output word sits in a register; a new word is accepted while it waits,
// but the next result is held back until the receiver takes the first.
// Depends on pli_pkg, pli_ctrl, pli_dp, pli_ram and the macros header.
`include "piecewise_linear_interpolator_top_macros.svh"

module piecewise_linear_interpolator_top #(
  parameter int MAX_NODES = pli_pkg::MAX_NODES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [pli_pkg::KIND_W-1:0]         kind,
  input  logic signed [pli_pkg::DATA_W-1:0]  x_value,
  input  logic signed [pli_pkg::DATA_W-1:0]  y_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [pli_pkg::STATUS_W-1:0]       status,
  output logic signed [pli_pkg::DATA_W-1:0]  y_result,
  output logic [pli_pkg::COUNT_OUT_W-1:0]    node_count,
  input  logic                               cfg_we,
  input  logic [pli_pkg::GAP_W-1:0]          cfg_data
);
  import pli_pkg::*;

  localparam int AW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);

  cmd_t          cmd;
  sts_t          sts;
  logic [CW-1:0] count;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] proc_idx;

  pli_ctrl #(.MAX_NODES(MAX_NODES), .AW(AW), .CW(CW)) u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .kind(kind),
    .count(count), .sts(sts), .cmd(cmd), .rd_addr(rd_addr), .proc_idx(proc_idx)
  );

  pli_dp #(.MAX_NODES(MAX_NODES), .AW(AW), .CW(CW)) u_dp (
    .clk(clk), .rst(rst), .x_value(x_value), .y_value(y_value),
    .cfg_we(cfg_we), .cfg_data(cfg_data), .cmd(cmd), .rd_addr(rd_addr),
    .proc_idx(proc_idx), .sts(sts), .count(count), .out_valid(out_valid),
    .out_ready(out_ready), .status(status), .y_result(y_result),
    .node_count(node_count)
  );

  // The table never holds more nodes than it has room for.
  `PLI_ASSERT_NOW(a_count_max, 1'b1, count <= CW'(MAX_NODES))
  // Every error word carries a zero value.
  `PLI_ASSERT_NOW(a_err_zero, out_valid && status != ST_OK, y_result == '0)
  // One word at a time: acceptance closes the input until the work is done.
  `PLI_ASSERT_NEXT(a_one_word, in_valid && in_ready, !in_ready)

endmodule
